[hdl/tcp_stream_reassembly_tracker_defines.svh]
// Assertion macros for the TCP stream reassembly tracker.
// No dependencies; included by the top level only.
`ifndef TCP_STREAM_REASSEMBLY_TRACKER_DEFINES_SVH
`define TCP_STREAM_REASSEMBLY_TRACKER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TRST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tracker check failed: same-cycle rule");

// antecedent implies consequent in the next cycle
`define TRST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tracker check failed: next-cycle rule");

`endif

[hdl/trst_pkg.sv]
// Shared types and constants of the TCP stream reassembly tracker.
// No dependencies; used by the cell, the chain and the top level.
`default_nettype none

package trst_pkg;

   localparam int TRST_MAX_HELD = 32;

   localparam logic [3:0] CSR_FIRST_ADDR = 4'd0;
   localparam logic [3:0] CSR_FIRST_PORT = 4'd1;

   typedef struct packed {
      logic [31:0] seq;
      logic [15:0] len;
      logic        syn;
      logic        fin;
      logic        psh;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IGNORED   = 2'd0,
      ST_HELD      = 2'd1,
      ST_EVICTED   = 2'd2,
      ST_DELIVERED = 2'd3
   } status_type;

   typedef struct packed {
      logic        direction;
      status_type  status;
      logic        from_held;
      logic [4:0]  slot;
      logic [15:0] skip;
      logic [15:0] newb;
      logic        parse;
   } result_type;

   // operation on a direction's held chain: keep or drop the head, or write a new entry at the tail
   typedef enum logic [2:0] {
      OP_NONE,
      OP_KEEP,
      OP_DROP,
      OP_WRITE,
      OP_EVICT_WRITE
   } chain_op_type;

   typedef enum logic [1:0] {
      SEL_HOLD,
      SEL_SHIFT,
      SEL_HEAD,
      SEL_NEW
   } cell_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HEAD,
      S_PASS_INIT,
      S_SCAN,
      S_SKIP,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

[hdl/trst_cell.sv]
// One held-segment cell: keeps, shifts in from its neighbor, takes the head or a new entry.
// Depends on trst_pkg.
`default_nettype none

module trst_cell (
   input  wire                    clock,
   input  trst_pkg::cell_sel_type sel,
   input  trst_pkg::entry_type    right_entry,
   input  trst_pkg::entry_type    head_entry,
   input  trst_pkg::entry_type    new_entry,
   output trst_pkg::entry_type    entry
);

   trst_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      case (sel)
         trst_pkg::SEL_SHIFT: entry_in = right_entry;
         trst_pkg::SEL_HEAD:  entry_in = head_entry;
         trst_pkg::SEL_NEW:   entry_in = new_entry;
         default:             entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

[hdl/trst_chain.sv]
// Held-segment store of one direction: a row of cells kept compact in arrival order.
// Depends on trst_pkg and trst_cell.
`default_nettype none

module trst_chain #(
   parameter int MAX_HELD = trst_pkg::TRST_MAX_HELD,
   localparam int CW = $clog2(MAX_HELD + 1)
) (
   input  wire                    clock,
   input  wire                    reset,
   input  trst_pkg::chain_op_type op,
   input  trst_pkg::entry_type    new_entry,
   output trst_pkg::entry_type    head,
   output logic [CW-1:0]          count
);

   trst_pkg::entry_type ent [MAX_HELD];
   logic [CW-1:0] count_ff, count_in;

   for (genvar i = 0; i < MAX_HELD; i++) begin : g_cell
      trst_pkg::cell_sel_type sel;
      trst_pkg::entry_type    right;

      if (i < MAX_HELD - 1) begin : g_mid
         assign right = ent[i+1];
      end else begin : g_end
         assign right = ent[i];
      end

      always_comb begin
         case (op)
            // rotation: the tail cell takes the old head
            trst_pkg::OP_KEEP:
               sel = (count_ff == CW'(i + 1)) ? trst_pkg::SEL_HEAD : trst_pkg::SEL_SHIFT;
            trst_pkg::OP_DROP:
               sel = trst_pkg::SEL_SHIFT;
            trst_pkg::OP_WRITE:
               sel = (count_ff == CW'(i)) ? trst_pkg::SEL_NEW : trst_pkg::SEL_HOLD;
            trst_pkg::OP_EVICT_WRITE:
               sel = (i == MAX_HELD - 1) ? trst_pkg::SEL_NEW : trst_pkg::SEL_SHIFT;
            default:
               sel = trst_pkg::SEL_HOLD;
         endcase
      end

      trst_cell u_cell (
         .clock       (clock),
         .sel         (sel),
         .right_entry (right),
         .head_entry  (ent[0]),
         .new_entry   (new_entry),
         .entry       (ent[i])
      );
   end

   always_comb begin
      case (op)
         trst_pkg::OP_DROP:  count_in = count_ff - CW'(1);
         trst_pkg::OP_WRITE: count_in = count_ff + CW'(1);
         default:            count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = ent[0];
   assign count = count_ff;

endmodule

`default_nettype wire

[hdl/tcp_stream_reassembly_tracker.sv]
// Top level of the TCP stream reassembly tracker: control, per-direction state, result register.
// Depends on trst_pkg, trst_chain and the assertion header.
//
// Tracks one TCP connection from segment headers. Each accepted word yields one or more result
// words, the final one marked by rsp_last. An ignored or held segment passes through the head
// and finish states before its result sits in the output register. A delivery that brings new
// bytes scans the held chain of its direction through its head cell, one held entry per cycle
// unless a due entry waits on a stalled output; each held entry that becomes due ends the pass,
// the rest of the chain rotates back into order and a new pass starts. The block takes the next
// word once the last result of the previous one is in the output register.
`default_nettype none

`include "tcp_stream_reassembly_tracker_defines.svh"

module tcp_stream_reassembly_tracker #(
   parameter int MAX_HELD = trst_pkg::TRST_MAX_HELD
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [3:0]  csr_index,
   input  wire  [31:0] csr_wdata,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_source_address,
   input  wire  [15:0] req_source_port,
   input  wire  [31:0] req_sequence_number,
   input  wire  [15:0] req_payload_length,
   input  wire         req_syn_flag,
   input  wire         req_fin_flag,
   input  wire         req_push_flag,
   input  wire         req_ack_flag,
   input  wire  [31:0] req_acknowledge_number,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic        rsp_direction,
   output logic [1:0]  rsp_status,
   output logic        rsp_from_held,
   output logic [4:0]  rsp_held_slot,
   output logic [15:0] rsp_skip_bytes,
   output logic [15:0] rsp_new_bytes,
   output logic        rsp_parse_now,
   output logic        rsp_connection_closed,
   output logic        rsp_last
);

   localparam int CW = $clog2(MAX_HELD + 1);

   // configuration
   logic [31:0] cfg_addr_ff;
   logic [15:0] cfg_port_ff;

   // latched segment
   trst_pkg::entry_type in_ent_ff;
   logic        in_ack_ff;
   logic [31:0] in_ackno_ff;
   logic        dir_ff, dir_in;

   trst_pkg::state_type state_ff, state_in;
   logic [CW-1:0] r_ff, r_in, j_ff, j_in;

   logic [1:0]        started_ff, started_in;
   logic [1:0][31:0]  next_ff, next_in;
   logic [1:0]        fin_seen_ff, fin_seen_in;
   logic [1:0][31:0]  fin_seq_ff, fin_seq_in;
   logic [1:0]        fin_acked_ff, fin_acked_in;
   logic              closed_ff, closed_in;

   trst_pkg::result_type pend_ff, pend_in, out_ff, out_in;
   logic pend_valid_ff, pend_valid_in;
   logic rsp_valid_ff, rsp_valid_in, out_last_ff, out_last_in, out_closed_ff, out_closed_in;

   // held chains
   trst_pkg::chain_op_type op, op0, op1;
   trst_pkg::entry_type    head0, head1, head_d;
   logic [CW-1:0]          count0, count1, count_d;

   // delivery unit
   trst_pkg::entry_type dv_ent;
   logic [31:0] dv_next, dv_off, dv_end, dv_newnext, eff_next;
   logic [15:0] dv_nb;
   logic        stale;

   trst_pkg::result_type res;
   logic push, out_free, accept;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != trst_pkg::S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign op0 = (dir_ff == 1'b0) ? op : trst_pkg::OP_NONE;
   assign op1 = (dir_ff == 1'b1) ? op : trst_pkg::OP_NONE;

   trst_chain #(.MAX_HELD(MAX_HELD)) u_chain0 (
      .clock(clock), .reset(reset), .op(op0), .new_entry(in_ent_ff),
      .head(head0), .count(count0)
   );

   trst_chain #(.MAX_HELD(MAX_HELD)) u_chain1 (
      .clock(clock), .reset(reset), .op(op1), .new_entry(in_ent_ff),
      .head(head1), .count(count1)
   );

   assign head_d  = dir_ff ? head1 : head0;
   assign count_d = dir_ff ? count1 : count0;

   assign eff_next = started_ff[dir_ff] ? next_ff[dir_ff] : in_ent_ff.seq;
   assign dv_ent   = (state_ff == trst_pkg::S_HEAD) ? in_ent_ff : head_d;
   assign dv_next  = (state_ff == trst_pkg::S_HEAD) ? eff_next : next_ff[dir_ff];

   always_comb begin
      dv_off = dv_next - dv_ent.seq;
      dv_nb  = ({16'b0, dv_ent.len} > dv_off) ? (dv_ent.len - dv_off[15:0]) : 16'd0;
      dv_end = dv_ent.seq + 32'(dv_ent.len) + 32'(dv_ent.syn) + 32'(dv_ent.fin);
      dv_newnext = (dv_end > dv_next) ? dv_end : dv_next;
      stale = ({1'b0, head_d.seq} + 33'(head_d.len)) <= {1'b0, next_ff[dir_ff]};
   end

   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      r_in          = r_ff;
      j_in          = j_ff;
      started_in    = started_ff;
      next_in       = next_ff;
      fin_seen_in   = fin_seen_ff;
      fin_seq_in    = fin_seq_ff;
      fin_acked_in  = fin_acked_ff;
      closed_in     = closed_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_closed_in = out_closed_ff;
      rsp_valid_in  = out_free ? 1'b0 : rsp_valid_ff;
      op            = trst_pkg::OP_NONE;
      push          = 1'b0;
      res           = '0;
      res.direction = dir_ff;

      unique case (state_ff)
         trst_pkg::S_IDLE: begin
            if (accept) begin
               dir_in   = (req_source_address == cfg_addr_ff) &&
                          (req_source_port == cfg_port_ff);
               state_in = trst_pkg::S_HEAD;
            end
         end
         trst_pkg::S_HEAD: begin
            // close check on the other direction, unaffected by this word's deliveries
            if (fin_seen_ff[!dir_ff] && in_ack_ff && (in_ackno_ff == fin_seq_ff[!dir_ff])) begin
               fin_acked_in[!dir_ff] = 1'b1;
            end
            closed_in = &fin_acked_in;
            push      = 1'b1;
            state_in  = trst_pkg::S_FINISH;
            if (!started_ff[dir_ff] && !in_ent_ff.syn) begin
               res.status = trst_pkg::ST_IGNORED;
            end else if (in_ent_ff.seq > eff_next) begin
               if (count_d >= CW'(MAX_HELD)) begin
                  op         = trst_pkg::OP_EVICT_WRITE;
                  res.status = trst_pkg::ST_EVICTED;
                  res.slot   = 5'(MAX_HELD - 1);
               end else begin
                  op         = trst_pkg::OP_WRITE;
                  res.status = trst_pkg::ST_HELD;
                  res.slot   = 5'(count_d);
               end
            end else begin
               next_in[dir_ff]    = dv_newnext;
               started_in[dir_ff] = 1'b1;
               if (in_ent_ff.fin) begin
                  fin_seen_in[dir_ff] = 1'b1;
                  fin_seq_in[dir_ff]  = in_ent_ff.seq + 32'(in_ent_ff.len) + 32'd1;
               end
               res.status = trst_pkg::ST_DELIVERED;
               res.skip   = in_ent_ff.len - dv_nb;
               res.newb   = dv_nb;
               res.parse  = in_ent_ff.psh || in_ent_ff.fin;
               if (dv_nb != 16'd0) begin
                  state_in = trst_pkg::S_PASS_INIT;
               end
            end
         end
         trst_pkg::S_PASS_INIT: begin
            r_in     = count_d;
            j_in     = '0;
            state_in = trst_pkg::S_SCAN;
         end
         trst_pkg::S_SCAN: begin
            if (r_ff == '0) begin
               state_in = trst_pkg::S_FINISH;
            end else if (head_d.seq > next_ff[dir_ff]) begin
               op   = trst_pkg::OP_KEEP;
               j_in = j_ff + CW'(1);
               r_in = r_ff - CW'(1);
            end else if (stale) begin
               op   = trst_pkg::OP_DROP;
               r_in = r_ff - CW'(1);
            end else if (!pend_valid_ff || out_free) begin
               op                 = trst_pkg::OP_DROP;
               push               = 1'b1;
               next_in[dir_ff]    = dv_newnext;
               started_in[dir_ff] = 1'b1;
               if (head_d.fin) begin
                  fin_seen_in[dir_ff] = 1'b1;
                  fin_seq_in[dir_ff]  = head_d.seq + 32'(head_d.len) + 32'd1;
               end
               res.status    = trst_pkg::ST_DELIVERED;
               res.from_held = 1'b1;
               res.slot      = 5'(j_ff);
               res.skip      = head_d.len - dv_nb;
               res.newb      = dv_nb;
               res.parse     = head_d.psh || head_d.fin;
               r_in          = r_ff - CW'(1);
               // rotate the untouched rest back behind the kept entries
               state_in = (r_ff == CW'(1)) ? trst_pkg::S_PASS_INIT : trst_pkg::S_SKIP;
            end
         end
         trst_pkg::S_SKIP: begin
            op   = trst_pkg::OP_KEEP;
            r_in = r_ff - CW'(1);
            if (r_ff == CW'(1)) begin
               state_in = trst_pkg::S_PASS_INIT;
            end
         end
         trst_pkg::S_FINISH: begin
            if (out_free) begin
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               out_closed_in = closed_ff;
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = trst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = trst_pkg::S_IDLE;
         end
      endcase

      // a new result pushes the pending one out, which is then known not to be the final word
      if (push) begin
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            out_last_in   = 1'b0;
            out_closed_in = closed_ff;
            rsp_valid_in  = 1'b1;
         end
         pend_in       = res;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= trst_pkg::S_IDLE;
         started_ff    <= '0;
         next_ff       <= '0;
         fin_seen_ff   <= '0;
         fin_seq_ff    <= '0;
         fin_acked_ff  <= '0;
         closed_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         cfg_addr_ff   <= '0;
         cfg_port_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         next_ff       <= next_in;
         fin_seen_ff   <= fin_seen_in;
         fin_seq_ff    <= fin_seq_in;
         fin_acked_ff  <= fin_acked_in;
         closed_ff     <= closed_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               trst_pkg::CSR_FIRST_ADDR: cfg_addr_ff <= csr_wdata;
               trst_pkg::CSR_FIRST_PORT: cfg_port_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dir_ff        <= dir_in;
      r_ff          <= r_in;
      j_ff          <= j_in;
      pend_ff       <= pend_in;
      out_ff        <= out_in;
      out_last_ff   <= out_last_in;
      out_closed_ff <= out_closed_in;
      if (accept) begin
         in_ent_ff.seq <= req_sequence_number;
         in_ent_ff.len <= req_payload_length;
         in_ent_ff.syn <= req_syn_flag;
         in_ent_ff.fin <= req_fin_flag;
         in_ent_ff.psh <= req_push_flag;
         in_ack_ff     <= req_ack_flag;
         in_ackno_ff   <= req_acknowledge_number;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_direction         = out_ff.direction;
   assign rsp_status            = out_ff.status;
   assign rsp_from_held         = out_ff.from_held;
   assign rsp_held_slot         = out_ff.slot;
   assign rsp_skip_bytes        = out_ff.skip;
   assign rsp_new_bytes         = out_ff.newb;
   assign rsp_parse_now         = out_ff.parse;
   assign rsp_connection_closed = out_closed_ff;
   assign rsp_last              = out_last_ff;

   `TRST_ASSERT_NEXT(a_finish_emits_last, clock, reset,
      (state_ff == trst_pkg::S_FINISH) && out_free, rsp_valid && rsp_last)
   `TRST_ASSERT_NOW(a_accept_no_pending, clock, reset, accept, !pend_valid_ff)
   `TRST_ASSERT_NOW(a_count_bound, clock, reset,
      state_ff == trst_pkg::S_HEAD, count_d <= CW'(MAX_HELD))

endmodule

`default_nettype wire

[tb/tcp_stream_reassembly_tracker_checker.sv]
// Checker for the TCP stream reassembly tracker: tracks register writes, predicts result words
// per accepted segment word and compares them with the result channel. Depends on trst_pkg.
`timescale 1ns / 1ps

module tcp_stream_reassembly_tracker_checker (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_valid,
   input  wire               csr_ready,
   input  wire  [3:0]        csr_index,
   input  wire  [31:0]       csr_wdata,
   input  wire               req_valid,
   input  wire               req_stall,
   input  wire  [31:0]       req_source_address,
   input  wire  [15:0]       req_source_port,
   input  wire  [31:0]       req_sequence_number,
   input  wire  [15:0]       req_payload_length,
   input  wire               req_syn_flag,
   input  wire               req_fin_flag,
   input  wire               req_push_flag,
   input  wire               req_ack_flag,
   input  wire  [31:0]       req_acknowledge_number,
   input  wire               rsp_valid,
   input  wire               rsp_stall,
   input  wire               rsp_direction,
   input  wire  [1:0]        rsp_status,
   input  wire               rsp_from_held,
   input  wire  [4:0]        rsp_held_slot,
   input  wire  [15:0]       rsp_skip_bytes,
   input  wire  [15:0]       rsp_new_bytes,
   input  wire               rsp_parse_now,
   input  wire               rsp_connection_closed,
   input  wire               rsp_last,
   output int                fail_count,
   output int                pending,
   output int                checked_count,
   output logic [1:0]        stream_live,
   output logic [1:0][31:0]  stream_next,
   output logic [1:0][31:0]  stream_fin_end
);

   localparam int HELD_DEPTH = trst_pkg::TRST_MAX_HELD;

   typedef struct packed {
      logic                 dir;
      trst_pkg::status_type status;
      logic                 from_held;
      logic [4:0]           slot;
      logic [15:0]          skip;
      logic [15:0]          newb;
      logic                 parse;
      logic                 closed;
      logic                 last;
   } seg_result_type;

   seg_result_type results_due[$];
   seg_result_type step_words[$];

   logic [31:0] cfg_addr;
   logic [15:0] cfg_port;
   logic [1:0]  fin_seen, fin_acked;
   logic [31:0] held_seq [2][HELD_DEPTH];
   logic [15:0] held_len [2][HELD_DEPTH];
   logic [2:0]  held_fl  [2][HELD_DEPTH];  // {psh, fin, syn}
   int          held_cnt [2];

   assign pending = results_due.size();

   task automatic drop_held(input int d, input int i);
      for (int j = i; j + 1 < held_cnt[d]; j++) begin
         held_seq[d][j] = held_seq[d][j + 1];
         held_len[d][j] = held_len[d][j + 1];
         held_fl[d][j]  = held_fl[d][j + 1];
      end
      held_cnt[d]--;
   endtask

   task automatic deliver_segment(input int d, input logic [31:0] seq, input logic [15:0] len,
                                  input logic [2:0] fl, input logic from_held,
                                  input logic [4:0] slot, output logic [15:0] nb);
      logic [31:0] off, seg_end;
      seg_result_type w;
      off = stream_next[d] - seq;
      nb = ({16'd0, len} > off) ? len - off[15:0] : 16'd0;
      seg_end = seq + 32'(len) + 32'(fl[0]) + 32'(fl[1]);
      if (seg_end > stream_next[d]) stream_next[d] = seg_end;
      stream_live[d] = 1'b1;
      if (fl[1]) begin
         fin_seen[d] = 1'b1;
         stream_fin_end[d] = seq + 32'(len) + 32'd1;
      end
      w = '0;
      w.dir = d[0];
      w.status = trst_pkg::ST_DELIVERED;
      w.from_held = from_held;
      w.slot = slot;
      w.skip = len - nb;
      w.newb = nb;
      w.parse = fl[2] | fl[1];
      step_words = {step_words, w};
   endtask

   task automatic predict_segment();
      int d, s, j;
      logic [2:0] fl;
      logic [15:0] nb;
      logic found, closed;
      logic [32:0] held_end;
      seg_result_type w;
      d = (req_source_address == cfg_addr && req_source_port == cfg_port) ? 1 : 0;
      s = d ^ 1;
      fl = {req_push_flag, req_fin_flag, req_syn_flag};
      step_words.delete();
      w = '0;
      w.dir = d[0];
      if (!stream_live[d] && !req_syn_flag) begin
         w.status = trst_pkg::ST_IGNORED;
         step_words = {step_words, w};
      end else begin
         if (!stream_live[d]) stream_next[d] = req_sequence_number;
         if (req_sequence_number > stream_next[d]) begin
            w.status = trst_pkg::ST_HELD;
            if (held_cnt[d] >= HELD_DEPTH) begin
               drop_held(d, 0);
               w.status = trst_pkg::ST_EVICTED;
            end
            w.slot = held_cnt[d][4:0];
            held_seq[d][held_cnt[d]] = req_sequence_number;
            held_len[d][held_cnt[d]] = req_payload_length;
            held_fl[d][held_cnt[d]]  = fl;
            held_cnt[d]++;
            step_words = {step_words, w};
         end else begin
            deliver_segment(d, req_sequence_number, req_payload_length, fl, 1'b0, 5'd0, nb);
            found = (nb != 0);
            // rescan the held entries from the oldest after each delivery from the store
            while (found && step_words.size() < 1 + HELD_DEPTH) begin
               found = 1'b0;
               j = 0;
               while (j < held_cnt[d]) begin
                  held_end = {1'b0, held_seq[d][j]} + 33'(held_len[d][j]);
                  if (held_seq[d][j] > stream_next[d]) begin
                     j++;
                  end else if (held_end <= {1'b0, stream_next[d]}) begin
                     drop_held(d, j);
                  end else begin
                     deliver_segment(d, held_seq[d][j], held_len[d][j], held_fl[d][j],
                                     1'b1, j[4:0], nb);
                     drop_held(d, j);
                     found = 1'b1;
                     break;
                  end
               end
            end
         end
      end
      if (fin_seen[s] && req_ack_flag && req_acknowledge_number == stream_fin_end[s])
         fin_acked[s] = 1'b1;
      closed = fin_acked[0] & fin_acked[1];
      foreach (step_words[i]) begin
         w = step_words[i];
         w.closed = closed;
         w.last = (i == step_words.size() - 1);
         results_due = {results_due, w};
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: result mismatch on %s: expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      seg_result_type w;
      if (reset) begin
         cfg_addr = '0;
         cfg_port = '0;
         stream_live = '0;
         stream_next = '0;
         stream_fin_end = '0;
         fin_seen = '0;
         fin_acked = '0;
         held_cnt[0] = 0;
         held_cnt[1] = 0;
         results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == trst_pkg::CSR_FIRST_ADDR) cfg_addr = csr_wdata;
            else if (csr_index == trst_pkg::CSR_FIRST_PORT) cfg_port = csr_wdata[15:0];
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $display("%0t: result word with nothing expected, got status %0d", $time,
                        rsp_status);
               fail_count++;
            end else begin
               w = results_due.pop_front();
               checked_count++;
               check_field("direction", 32'(w.dir), 32'(rsp_direction));
               check_field("status", 32'(w.status), 32'(rsp_status));
               check_field("from_held", 32'(w.from_held), 32'(rsp_from_held));
               check_field("held_slot", 32'(w.slot), 32'(rsp_held_slot));
               check_field("skip_bytes", 32'(w.skip), 32'(rsp_skip_bytes));
               check_field("new_bytes", 32'(w.newb), 32'(rsp_new_bytes));
               check_field("parse_now", 32'(w.parse), 32'(rsp_parse_now));
               check_field("connection_closed", 32'(w.closed), 32'(rsp_connection_closed));
               check_field("last", 32'(w.last), 32'(rsp_last));
            end
         end
         if (req_valid && !req_stall) predict_segment();
      end
   end

   initial begin
      fail_count = 0;
      checked_count = 0;
   end

endmodule

[tb/tcp_stream_reassembly_tracker_tb.sv]
// Top of the TCP stream reassembly tracker testbench: clock, reset, stimulus and verdict.
// Depends on trst_pkg, the tracker RTL and tcp_stream_reassembly_tracker_checker.
`timescale 1ns / 1ps

module tcp_stream_reassembly_tracker_tb;

   localparam logic [3:0] CSR_SPARE = 4'd15;  // index past the register list, must be ignored
   localparam int ITEM_TARGET = 170;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic [3:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic [31:0] req_source_address = '0;
   logic [15:0] req_source_port = '0;
   logic [31:0] req_sequence_number = '0;
   logic [15:0] req_payload_length = '0;
   logic req_syn_flag = 1'b0, req_fin_flag = 1'b0, req_push_flag = 1'b0, req_ack_flag = 1'b0;
   logic [31:0] req_acknowledge_number = '0;
   logic rsp_stall = 1'b0;
   wire csr_ready, req_stall, rsp_valid, rsp_direction, rsp_from_held, rsp_parse_now;
   wire rsp_connection_closed, rsp_last;
   wire [1:0] rsp_status;
   wire [4:0] rsp_held_slot;
   wire [15:0] rsp_skip_bytes, rsp_new_bytes;

   int fail_count, pending, checked_count, sent;
   logic [1:0] stream_live;
   logic [1:0][31:0] stream_next, stream_fin_end;
   logic quiet = 1'b0;
   logic [31:0] cfg_addr;
   logic [15:0] cfg_port;

   always #4 clock = ~clock;

   tcp_stream_reassembly_tracker dut (.*);
   tcp_stream_reassembly_tracker_checker checker_i (.*);

   always @(negedge clock) rsp_stall = !quiet && ($urandom_range(99) < 18);

   task automatic csr_write(input logic [3:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      if (idx == trst_pkg::CSR_FIRST_ADDR) cfg_addr = data;
      if (idx == trst_pkg::CSR_FIRST_PORT) cfg_port = data[15:0];
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send(input int d, input logic [31:0] seq, input logic [15:0] len,
                       input logic syn, input logic fin, input logic psh, input logic ack,
                       input logic [31:0] ackno);
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 18) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      if (d == 1) begin
         req_source_address = cfg_addr;
         req_source_port = cfg_port;
      end else begin
         req_source_address = $urandom;
         req_source_port = 16'($urandom);
         if (req_source_address == cfg_addr && req_source_port == cfg_port)
            req_source_address[0] = ~req_source_address[0];
      end
      req_sequence_number = seq;
      req_payload_length = len;
      req_syn_flag = syn;
      req_fin_flag = fin;
      req_push_flag = psh;
      req_ack_flag = ack;
      req_acknowledge_number = ackno;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   function automatic logic [15:0] pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 5) return 16'hFFFF;
      if (r < 15) return 16'd0;
      if (r < 20) return 16'($urandom);
      return 16'($urandom_range(1, 1460));
   endfunction

   // out-of-order burst: hold back the first word, send n after it, then fill the hole
   task automatic reorder_burst(input int d, input int n);
      logic [31:0] base, seq;
      logic [15:0] gap_len, len;
      base = stream_next[d];
      gap_len = 16'($urandom_range(1, 1460));
      seq = base + 32'(gap_len);
      for (int i = 0; i < n; i++) begin
         len = (i == n - 1 || $urandom_range(9) > 0) ? 16'($urandom_range(1, 1000)) : 16'd0;
         send(d, seq, len, 1'b0, $urandom_range(19) == 0, 1'($urandom), 1'($urandom),
              $urandom);
         seq += 32'(len);
      end
      send(d, base, gap_len, 1'b0, 1'b0, 1'($urandom), 1'($urandom), $urandom);
   endtask

   task automatic random_item();
      int d, r;
      logic [31:0] nx, ackno;
      logic ack;
      d = $urandom_range(1);
      nx = stream_next[d];
      ack = 1'($urandom);
      ackno = $urandom_range(1) ? stream_fin_end[d ^ 1] : $urandom;
      r = $urandom_range(99);
      if (!stream_live[d] && r < 90)
         send(d, $urandom_range(32'h7FFF_0000), pick_len(), 1'b1, 1'b0, 1'($urandom), ack,
              ackno);
      else if (r < 45)
         send(d, nx, pick_len(), $urandom_range(19) == 0, $urandom_range(19) == 0,
              1'($urandom), ack, ackno);
      else if (r < 55)
         send(d, nx - $urandom_range(300), pick_len(), 1'b0, 1'b0, 1'($urandom), ack, ackno);
      else if (r < 65)
         send(d, nx + 1 + $urandom_range(4000), pick_len(), $urandom_range(9) == 0,
              $urandom_range(9) == 0, 1'($urandom), ack, ackno);
      else if (r < 77)
         reorder_burst(d, ($urandom_range(7) == 0) ? $urandom_range(30, 36)
                                                  : $urandom_range(1, 6));
      else if (r < 87)
         send(d, nx, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, stream_fin_end[d ^ 1]);
      else
         send(d, $urandom, 16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              1'($urandom), $urandom);
   endtask

   initial begin
      sent = 0;
      cfg_addr = '0;
      cfg_port = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write(trst_pkg::CSR_FIRST_ADDR, 32'h0A00_0001);
      csr_write(trst_pkg::CSR_FIRST_PORT, 32'h0000_1F90);
      csr_write(CSR_SPARE, 32'hDEAD_BEEF);

      // directed: ignore before SYN, holds, rescan chain, stale and overlapping words, close
      send(0, 32'h100, 16'd10, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      send(1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
      send(1, 32'd1000, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0);
      send(1, 32'd1001, 16'd100, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0);
      send(1, 32'd1201, 16'd50, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      send(1, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      send(1, 32'd1251, 16'd30, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0);
      send(1, 32'd1101, 16'd100, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      send(1, 32'd1001, 16'd100, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      send(1, 32'd1250, 16'd60, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);
      send(0, 32'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b0, 32'd0);
      send(0, 32'd1, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b0, 32'd0);
      send(0, 32'd65536, 16'd0, 1'b0, 1'b1, 1'b0, 1'b0, 32'd0);
      send(1, 32'd1310, 16'd5, 1'b0, 1'b1, 1'b0, 1'b1, 32'd65537);
      send(0, 32'd65537, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 32'd1316);
      send(1, 32'd1316, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, 32'd0);
      send(1, 32'd1400, 16'd10, 1'b1, 1'b1, 1'b1, 1'b0, 32'd0);
      send(1, 32'd1317, 16'd83, 1'b0, 1'b0, 1'b0, 1'b0, 32'd0);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            wait_drained();
            csr_write(trst_pkg::CSR_FIRST_ADDR, 32'h0);
            csr_write(trst_pkg::CSR_FIRST_PORT, 32'h0);
         end else if (phase == 2) begin
            wait_drained();
            csr_write(trst_pkg::CSR_FIRST_PORT, 32'h0000_FFFF);
            csr_write(trst_pkg::CSR_FIRST_ADDR, 32'hFFFF_FFFF);
         end
         while (sent < 18 + (ITEM_TARGET - 18) * (phase + 1) / 3) begin
            quiet = (phase == 0 && sent >= 50 && sent < 85);
            if (phase == 0 && sent >= 40 && sent < 42) wait_drained();
            random_item();
         end
         quiet = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b0;
      wait_drained();

      $display("Sent %0d segment words over three source settings; checked %0d result words.",
               sent, checked_count);
      $display("Covered ignored, held, evicting, stale, overlapping and rescanned deliveries.");
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout after %0t", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
